// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Assertion forms for the checker file of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// File: src/rusd_pkg.sv
// ----------------------------------------------------------------------------
// rusd_pkg
// Types, constants and float helpers of the upload sample decoder.
// ----------------------------------------------------------------------------
package rusd_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [APB_ADDR_W-1:0] REG_STEP_ADDR = 3'd0;
  localparam logic [31:0] STEP_RESET = 32'd968671824;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;
  localparam logic [7:0]  INDEX_EXP = 8'd150;  // integer operand: mant * 2^0

  typedef enum logic [1:0] {
    KIND_INT32 = 2'd0,
    KIND_FLOAT = 2'd1,
    KIND_HALF  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] raw;
    kind_t       kind;
    logic [15:0] index;
    logic [31:0] scale;
    logic        last;
    logic        mismatch;
  } item_t;

  // unpacked multiplier operand: value = mant * 2^(exp-150)
  typedef struct packed {
    logic        sign;
    logic [7:0]  exp;
    logic [23:0] mant;
    logic        nan;
    logic        inf;
    logic        zero;
  } fp_op_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [9:0]  esum;
    logic [47:0]        prod;
  } fp_prod_t;

  typedef struct packed {
    logic               sign;
    logic               nan;
    logic               inf;
    logic               zero;
    logic signed [10:0] expo;
    logic [5:0]         lz;
    logic [47:0]        prod;
  } fp_norm_t;

  // leading zero count, 64 when v is zero
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [63:0] x;
    logic [6:0]  n;
    x = v;
    n = '0;
    if (x[63:32] == 32'd0) begin n = n + 7'd32; x = {x[31:0], 32'd0}; end
    if (x[63:48] == 16'd0) begin n = n + 7'd16; x = {x[47:0], 16'd0}; end
    if (x[63:56] == 8'd0)  begin n = n + 7'd8;  x = {x[55:0], 8'd0};  end
    if (x[63:60] == 4'd0)  begin n = n + 7'd4;  x = {x[59:0], 4'd0};  end
    if (x[63:62] == 2'd0)  begin n = n + 7'd2;  x = {x[61:0], 2'd0};  end
    if (x[63] == 1'b0)     begin n = n + 7'd1;  x = {x[62:0], 1'b0};  end
    if (x[63] == 1'b0)     begin n = n + 7'd1; end
    return n;
  endfunction

  function automatic fp_op_t unpack_fp(input logic [31:0] f);
    fp_op_t o;
    o.sign = f[31];
    o.nan  = (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    o.inf  = (f[30:23] == 8'hFF) && (f[22:0] == 23'd0);
    o.zero = (f[30:23] == 8'h00) && (f[22:0] == 23'd0);
    o.exp  = (f[30:23] == 8'h00) ? 8'd1 : f[30:23];
    o.mant = {(f[30:23] != 8'h00), f[22:0]};
    return o;
  endfunction

  function automatic logic [31:0] half_to_float(input logic [15:0] h);
    logic [3:0] lz;
    logic [9:0] frac;
    logic [7:0] e;
    lz   = 4'(lzc64({h[9:0], 54'd0}));
    frac = 10'({h[9:0], 1'b0} << lz);
    e    = 8'd112 - {4'd0, lz};
    if (h[14:10] == 5'h1F) begin
      return {h[15], 8'hFF, h[9:0], 13'd0};
    end else if (h[14:10] != 5'd0) begin
      return {h[15], 3'd0, h[14:10] + 5'd0, 23'd0} +
             {1'b0, 8'd112, h[9:0], 13'd0};
    end else if (h[9:0] == 10'd0) begin
      return {h[15], 31'd0};
    end
    return {h[15], e, frac, 13'd0};
  endfunction

  // magnitude normalized here by lz; round to nearest even
  function automatic logic [31:0] int_to_float(input logic sign, input logic [31:0] mag,
                                               input logic [5:0] lz);
    logic [31:0] norm;
    logic        inc;
    logic [31:0] sum;
    norm = mag << lz;
    inc  = norm[7] & ((|norm[6:0]) | norm[8]);
    sum  = {1'b0, 8'd157 - {2'd0, lz}, 23'd0} + {8'd0, norm[31:8]} + {31'd0, inc};
    if (mag == 32'd0) begin
      return 32'd0;
    end
    return {sign, sum[30:0]};
  endfunction

  function automatic fp_prod_t mul_fp(input fp_op_t a, input fp_op_t b);
    fp_prod_t p;
    p.sign = a.sign ^ b.sign;
    p.nan  = a.nan | b.nan | (a.inf & b.zero) | (b.inf & a.zero);
    p.inf  = a.inf | b.inf;
    p.zero = a.zero | b.zero;
    p.esum = $signed({2'b00, a.exp}) + $signed({2'b00, b.exp});
    p.prod = a.mant * b.mant;
    return p;
  endfunction

  function automatic fp_norm_t norm_fp(input fp_prod_t p);
    fp_norm_t n;
    n.sign = p.sign;
    n.nan  = p.nan;
    n.inf  = p.inf;
    n.zero = p.zero | (p.prod == 48'd0);
    n.lz   = 6'(lzc64({p.prod, 16'd0}));
    n.prod = p.prod;
    n.expo = {p.esum[9], p.esum} - 11'sd126 - $signed({5'd0, n.lz});
    return n;
  endfunction

  function automatic logic [31:0] round_pack(input fp_norm_t n);
    logic [47:0]        norm;
    logic [5:0]         sh;
    logic [95:0]        wide;
    logic [23:0]        m;
    logic               inc;
    logic [9:0]         em1;
    logic [32:0]        sum;
    norm = n.prod << n.lz;
    if (n.expo >= 11'sd1) begin
      sh  = 6'd0;
      em1 = 10'(n.expo - 11'sd1);
    end else begin
      sh  = (n.expo < -11'sd46) ? 6'd48 : 6'(11'sd1 - n.expo);
      em1 = 10'd0;
    end
    wide = {norm, 48'd0} >> sh;
    m    = wide[95:72];
    inc  = wide[71] & ((|wide[70:0]) | m[0]);
    sum  = {em1, 23'd0} + {9'd0, m} + {32'd0, inc};
    if (n.nan) begin
      return QNAN_BITS;
    end else if (n.inf) begin
      return {n.sign, INF_BITS[30:0]};
    end else if (n.zero) begin
      return {n.sign, 31'd0};
    end else if (sum >= {1'b0, INF_BITS}) begin
      return {n.sign, INF_BITS[30:0]};
    end
    return {n.sign, sum[30:0]};
  endfunction

endpackage

// File: src/rusd_ifs.sv
// ----------------------------------------------------------------------------
// rusd interfaces
// Valid/ready channels for upload bytes and decoded samples.
// ----------------------------------------------------------------------------
interface rusd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface rusd_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample_index;
  logic [31:0] sample_time;
  logic [31:0] sample_value;
  logic        final_item;
  logic        count_mismatch;
  modport source (output valid, sample_index, sample_time, sample_value, final_item,
                  count_mismatch, input ready);
  modport sink   (input valid, sample_index, sample_time, sample_value, final_item,
                  count_mismatch, output ready);
endinterface

// File: src/rusd_front.sv
// ----------------------------------------------------------------------------
// rusd_front
// Header parser and item assembler; pushes complete items to the queue.
// ----------------------------------------------------------------------------
module rusd_front (
  input  logic              clk,
  input  logic              rst,
  rusd_byte_if.sink         bytes,
  input  logic              q_full,
  output logic              push,
  output rusd_pkg::item_t   push_item
);

  localparam logic [2:0] HDR_TYPE   = 3'd0;
  localparam logic [2:0] HDR_CNT_LO = 3'd1;
  localparam logic [2:0] HDR_CNT_HI = 3'd2;
  localparam logic [2:0] HDR_SCL_0  = 3'd3;
  localparam logic [2:0] HDR_SCL_1  = 3'd4;
  localparam logic [2:0] HDR_SCL_2  = 3'd5;
  localparam logic [2:0] DATA_PHASE = 3'd7;

  logic [2:0]       hpos, hpos_next;
  rusd_pkg::kind_t  kind, kind_next;
  logic [15:0]      count, count_next;
  logic [31:0]      scale, scale_next;
  logic [31:0]      asm_r, asm_next;
  logic [1:0]       bii, bii_next;
  logic [15:0]      cnt, cnt_next;
  logic             accept;
  logic [31:0]      asm_new;
  logic             item_end;

  assign bytes.ready = !q_full;
  assign accept      = bytes.valid && bytes.ready;

  always_comb begin
    hpos_next  = hpos;
    kind_next  = kind;
    count_next = count;
    scale_next = scale;
    asm_next   = asm_r;
    bii_next   = bii;
    cnt_next   = cnt;
    push       = 1'b0;
    asm_new    = asm_r;
    asm_new[{bii, 3'b000} +: 8] = bytes.data_byte;
    item_end   = (kind == rusd_pkg::KIND_HALF) ? (bii != 2'd0) : (bii == 2'd3);

    push_item.raw      = asm_new;
    push_item.kind     = kind;
    push_item.index    = cnt;
    push_item.scale    = scale;
    push_item.last     = bytes.last_byte;
    push_item.mismatch = bytes.last_byte && (({1'b0, cnt} + 17'd1) != {1'b0, count});

    if (accept) begin
      if (hpos != DATA_PHASE) begin
        case (hpos)
          HDR_TYPE: begin
            case (bytes.data_byte[7:4])
              4'd5:    kind_next = rusd_pkg::KIND_FLOAT;
              4'd1:    kind_next = rusd_pkg::KIND_HALF;
              default: kind_next = rusd_pkg::KIND_INT32;
            endcase
          end
          HDR_CNT_LO: count_next[7:0]  = bytes.data_byte;
          HDR_CNT_HI: count_next[15:8] = bytes.data_byte;
          HDR_SCL_0:  scale_next[7:0]  = bytes.data_byte;
          HDR_SCL_1:  scale_next[15:8] = bytes.data_byte;
          HDR_SCL_2:  scale_next[23:16] = bytes.data_byte;
          default:    scale_next[31:24] = bytes.data_byte;
        endcase
        hpos_next = hpos + 3'd1;
      end else if (item_end) begin
        push     = 1'b1;
        cnt_next = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
        bii_next = 2'd0;
        asm_next = '0;
      end else begin
        bii_next = bii + 2'd1;
        asm_next = asm_new;
      end
      if (bytes.last_byte) begin
        hpos_next = HDR_TYPE;
        bii_next  = 2'd0;
        asm_next  = '0;
        cnt_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hpos  <= HDR_TYPE;
      kind  <= rusd_pkg::KIND_INT32;
      count <= '0;
      scale <= '0;
      asm_r <= '0;
      bii   <= '0;
      cnt   <= '0;
    end else begin
      hpos  <= hpos_next;
      kind  <= kind_next;
      count <= count_next;
      scale <= scale_next;
      asm_r <= asm_next;
      bii   <= bii_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: src/rusd_queue.sv
// ----------------------------------------------------------------------------
// rusd_queue
// Small FIFO of assembled items between front and back.
module rusd_queue #(
  parameter int DEPTH = rusd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rusd_pkg::item_t push_item,
  output logic            full,
  output logic            head_valid,
  output rusd_pkg::item_t head_item,
  input  logic            pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rusd_pkg::item_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   fill;
  logic            do_pop;

  assign full       = (fill == CW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_item  = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push && !full, do_pop})
        2'b10:   fill <= fill + CW'(1);
        2'b01:   fill <= fill - CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: src/rusd_back.sv
// ----------------------------------------------------------------------------
// rusd_back
// Conversion and float multiply pipeline, five stages including output.
// ----------------------------------------------------------------------------
module rusd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  rusd_pkg::item_t head_item,
  output logic            pop,
  input  logic [31:0]     step,
  rusd_sample_if.source   samples
);

  typedef struct packed {
    logic [15:0] index;
    logic        last;
    logic        mismatch;
  } side_t;

  logic en;

  // stage 1: sign/magnitude and leading zeros, half and float decoded
  logic        v1;
  side_t       sd1;
  logic [31:0] scale1;
  logic        int1, sign1;
  logic [31:0] mag1;
  logic [5:0]  lz1;
  logic [31:0] bits1;
  logic [31:0] mag_c;

  // stage 2: unpacked operands
  logic             v2;
  side_t            sd2;
  rusd_pkg::fp_op_t op_a, op_b, op_c, op_d;

  // stage 3: raw products
  logic               v3;
  side_t              sd3;
  rusd_pkg::fp_prod_t pv3, pt3;

  // stage 4: normalize counts
  logic               v4;
  side_t              sd4;
  rusd_pkg::fp_norm_t nv4, nt4;

  assign en    = !samples.valid || samples.ready;
  assign pop   = en && head_valid;
  assign mag_c = head_item.raw[31] ? (~head_item.raw + 32'd1) : head_item.raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      samples.valid <= 1'b0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      samples.valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1    <= '{index: head_item.index, last: head_item.last,
                  mismatch: head_item.mismatch};
      scale1 <= head_item.scale;
      sign1  <= head_item.raw[31];
      mag1   <= mag_c;
      lz1    <= 6'(rusd_pkg::lzc64({mag_c, 32'd0}));
      int1   <= 1'b0;
      case (head_item.kind)
        rusd_pkg::KIND_FLOAT: bits1 <= head_item.raw;
        rusd_pkg::KIND_HALF:  bits1 <= rusd_pkg::half_to_float(head_item.raw[15:0]);
        default: begin
          bits1 <= head_item.raw;
          int1  <= 1'b1;
        end
      endcase

      sd2  <= sd1;
      op_a <= rusd_pkg::unpack_fp(scale1);
      op_b <= rusd_pkg::unpack_fp(int1 ? rusd_pkg::int_to_float(sign1, mag1, lz1) : bits1);
      op_c <= '{sign: 1'b0, exp: rusd_pkg::INDEX_EXP, mant: {8'd0, sd1.index},
                nan: 1'b0, inf: 1'b0, zero: (sd1.index == 16'd0)};
      op_d <= rusd_pkg::unpack_fp(step);

      sd3 <= sd2;
      pv3 <= rusd_pkg::mul_fp(op_a, op_b);
      pt3 <= rusd_pkg::mul_fp(op_c, op_d);

      sd4 <= sd3;
      nv4 <= rusd_pkg::norm_fp(pv3);
      nt4 <= rusd_pkg::norm_fp(pt3);

      samples.sample_index   <= sd4.index;
      samples.final_item     <= sd4.last;
      samples.count_mismatch <= sd4.mismatch;
      samples.sample_value   <= rusd_pkg::round_pack(nv4);
      samples.sample_time    <= rusd_pkg::round_pack(nt4);
    end
  end

endmodule

// File: src/recorder_upload_sample_decoder_core.sv
// ----------------------------------------------------------------------------
// recorder_upload_sample_decoder_core
// Decodes the byte stream of a recorder upload into scaled float32 samples.
// ----------------------------------------------------------------------------
// Bytes enter on the bytes channel, one byte per cycle, with no stall of its
// own: the first seven bytes of an upload are the header (type nibble, item
// count, float32 scale), after that every 4 bytes (2 for half float) complete
// one item, which gives one sample after the queue and back pipeline. Header
// bytes and bytes inside an item give no sample. Sustained rate is one byte
// per cycle, set by the front parser, which handles one byte a cycle; the back
// pipeline (int32 normalize, int-to-float round, two 24x24 multiplies, product
// normalize, round/pack) also takes one item per cycle while samples are taken.
// A 4-entry queue sits between parser and pipeline, so the bytes channel only
// stalls when the queue fills behind a stalled samples channel. All NaN results
// come out as 0x7FC00000. recording_step sits at APB byte address 0 and is to
// be written only while the block is idle, which the block does not enforce.
module recorder_upload_sample_decoder_core #(
  parameter int QUEUE_DEPTH = rusd_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  rusd_byte_if.sink                          bytes,
  rusd_sample_if.source                      samples,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rusd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rusd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rusd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  logic            push;
  rusd_pkg::item_t push_item;
  logic            q_full;
  logic            head_valid;
  rusd_pkg::item_t head_item;
  logic            pop;
  logic [31:0]     step;

  // config register: write on the access phase
  assign pready = 1'b1;
  assign prdata = (paddr == rusd_pkg::REG_STEP_ADDR) ? step : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= rusd_pkg::STEP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == rusd_pkg::REG_STEP_ADDR) begin
      step <= pwdata;
    end
  end

  // header parse and item assembly
  rusd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .bytes     (bytes),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decouples the parser from the float pipeline
  rusd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // conversion, multiplies and output register
  rusd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .step       (step),
    .samples    (samples)
  );

endmodule

// File: src/rusd_checker.sv
// ----------------------------------------------------------------------------
// rusd_checker
// Port-level checks of the upload sample decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rusd_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] sample_index,
  input logic [31:0] sample_time,
  input logic [31:0] sample_value,
  input logic        final_item,
  input logic        count_mismatch,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(sample_index) && $stable(sample_time) && $stable(sample_value))
  `ASSERT_CLK(a_mismatch_final, clk, rst, out_valid |-> (!count_mismatch || final_item))
  `ASSERT_CLK(a_step_readback, clk, rst, psel && penable && pwrite && paddr == 3'd0 |=> (paddr != 3'd0) || (prdata == $past(pwdata)))
  `ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && byte_ready)

endmodule

bind recorder_upload_sample_decoder_core rusd_checker u_rusd_checker (
  .clk            (clk),
  .rst            (rst),
  .byte_ready     (bytes.ready),
  .out_valid      (samples.valid),
  .out_ready      (samples.ready),
  .sample_index   (samples.sample_index),
  .sample_time    (samples.sample_time),
  .sample_value   (samples.sample_value),
  .final_item     (samples.final_item),
  .count_mismatch (samples.count_mismatch),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the upload sample decoder core. It feeds byte
// streams of uploads (directed table, then random uploads in several step
// settings) through the bytes channel with bursty timing. A bit-exact float32
// predictor or a typed table row gives each sample, checked in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;   // pipeline is 5 deep plus the 4-entry queue

  typedef struct {
    logic [15:0] index;
    logic [31:0] when;
    logic [31:0] value;
    logic        fin;
    logic        mism;
  } sample_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  // directed row: a byte, plus an optional typed expectation
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       typed;
    sample_t    want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [rusd_pkg::APB_ADDR_W-1:0] paddr;
  logic [rusd_pkg::APB_DATA_W-1:0] pwdata, prdata;
  logic pready;

  rusd_byte_if   in_if ();
  rusd_sample_if out_if ();

  recorder_upload_sample_decoder_core dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (in_if),
    .samples (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  logic [31:0]     step_bits = rusd_pkg::STEP_RESET;
  logic [2:0]      hdr_pos   = '0;
  rusd_pkg::kind_t cur_kind  = rusd_pkg::KIND_INT32;
  logic [15:0]     announced = '0;
  logic [31:0]     scale     = '0;
  logic [31:0]     assembly  = '0;
  logic [1:0]      byte_pos  = '0;
  logic [15:0]     emitted   = '0;

  sample_t    pending_samples[$];
  byte_item_t byte_queue[$];
  logic       typed_queue[$];     // per queued byte: use typed expectation
  sample_t    typed_want[$];

  int fails = 0;
  int got_count = 0;
  int cyc = 0;

  // --------------------------------------------------------------------------
  // float32 arithmetic, bit exact, round to nearest even
  // --------------------------------------------------------------------------
  // Rounds m * 2^e to float32 (subnormals and overflow included).
  function automatic logic [31:0] round_f32(logic s, logic [63:0] m, int e);
    int p, sh, ex;
    logic [127:0] w;
    logic [63:0] q;
    longint unsigned bits;
    if (m == 0) return {s, 31'd0};
    p = 63;
    while (!m[p]) p--;
    sh = p - 23;
    if (-149 - e > sh) sh = -149 - e;
    ex = e + sh + 149;
    if (sh > 0) begin
      if (sh > 127) sh = 127;
      w = {m, 64'd0} >> sh;
      q = w[127:64];
      if (w[63] && ((|w[62:0]) || q[0])) q = q + 64'd1;
    end else begin
      q = m << (-sh);
    end
    // exponent and mantissa add so that a rounding carry bumps the exponent
    bits = (longint'(ex) << 23) + q;
    if (bits >= 64'h7F80_0000) return {s, rusd_pkg::INF_BITS[30:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] fmul32(logic [31:0] a, logic [31:0] b);
    logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, s;
    logic [23:0] ma, mb;
    int ea, eb;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 0);
    a_zero = (a[30:0] == 0);
    b_zero = (b[30:0] == 0);
    s = a[31] ^ b[31];
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) return rusd_pkg::QNAN_BITS;
    if (a_inf || b_inf) return {s, rusd_pkg::INF_BITS[30:0]};
    if (a_zero || b_zero) return {s, 31'd0};
    ma = {(a[30:23] != 0), a[22:0]};
    mb = {(b[30:23] != 0), b[22:0]};
    ea = (a[30:23] != 0) ? int'(a[30:23]) : 1;
    eb = (b[30:23] != 0) ? int'(b[30:23]) : 1;
    return round_f32(s, 64'(ma) * 64'(mb), ea + eb - 300);
  endfunction

  function automatic logic [31:0] item_as_f32(logic [31:0] raw, rusd_pkg::kind_t k);
    logic [15:0] h;
    logic [31:0] mag;
    h = raw[15:0];
    case (k)
      rusd_pkg::KIND_FLOAT: return raw;
      rusd_pkg::KIND_HALF: begin
        if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
        if (h[14:10] == 5'h00) return round_f32(h[15], 64'(h[9:0]), -24);
        return round_f32(h[15], 64'(h[9:0]) + 64'd1024, int'(h[14:10]) - 25);
      end
      default: begin
        mag = raw[31] ? -raw : raw;   // 0x80000000 keeps its magnitude
        return round_f32(raw[31], 64'(mag), 0);
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Predictor: one accepted byte, at most one sample
  // --------------------------------------------------------------------------
  function automatic void decode_byte(logic [7:0] b, logic last, output logic made,
                                      output sample_t smp);
    logic [1:0] size_last;
    made = 0;
    smp = '{default: '0};
    if (hdr_pos < 3'd7) begin
      case (hdr_pos)
        3'd0: cur_kind = (b[7:4] == 4'd5) ? rusd_pkg::KIND_FLOAT :
                         (b[7:4] == 4'd1) ? rusd_pkg::KIND_HALF : rusd_pkg::KIND_INT32;
        3'd1: announced[7:0]  = b;
        3'd2: announced[15:8] = b;
        3'd3: scale[7:0]      = b;
        3'd4: scale[15:8]     = b;
        3'd5: scale[23:16]    = b;
        default: scale[31:24] = b;
      endcase
      hdr_pos = hdr_pos + 3'd1;
    end else begin
      size_last = (cur_kind == rusd_pkg::KIND_HALF) ? 2'd1 : 2'd3;
      assembly[byte_pos*8 +: 8] = b;
      if (byte_pos >= size_last) begin
        made = 1;
        smp.index = emitted;
        smp.when  = fmul32(round_f32(1'b0, 64'(emitted), 0), step_bits);
        smp.value = fmul32(scale, item_as_f32(assembly, cur_kind));
        smp.fin   = last;
        smp.mism  = last && ((17'(emitted) + 17'd1) != 17'(announced));
        if (emitted != 16'hFFFF) emitted = emitted + 16'd1;
        byte_pos = '0;
        assembly = '0;
      end else begin
        byte_pos = byte_pos + 2'd1;
      end
    end
    if (last) begin
      hdr_pos = '0;
      byte_pos = '0;
      assembly = '0;
      emitted = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Byte sender: bursts of random length, random gaps
  // --------------------------------------------------------------------------
  initial begin : sender
    int gap, burst;
    logic made, use_typed;
    sample_t smp, tw;
    byte_item_t it;
    gap = 0;
    burst = 1;
    in_if.valid     <= 0;
    in_if.data_byte <= 0;
    in_if.last_byte <= 0;
    forever begin
      @(posedge clk);
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.data_byte, in_if.last_byte, made, smp);
        use_typed = typed_queue.pop_front();
        if (use_typed) begin
          tw = typed_want.pop_front();
          smp = tw;
        end
        if (made || use_typed) pending_samples.push_back(smp);
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered item
      end else if (rst) begin
        in_if.valid <= 0;
      end else if (gap > 0) begin
        gap--;
        in_if.valid <= 0;
      end else if (byte_queue.size() > 0) begin
        it = byte_queue.pop_front();
        in_if.valid     <= 1;
        in_if.data_byte <= it.data;
        in_if.last_byte <= it.last;
        burst--;
        if (burst <= 0) begin
          burst = $urandom_range(1, 40);
          // some bursts run back to back
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_if.valid <= 0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sample receiver: own stall pattern plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    logic hold_done;
    sample_t want;
    hold = 0;
    hold_done = 0;
    out_if.ready <= 0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got_count++;
        if (pending_samples.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected sample idx=%0d", out_if.sample_index);
        end else begin
          want = pending_samples.pop_front();
          if (out_if.sample_index !== want.index || out_if.sample_time !== want.when ||
              out_if.sample_value !== want.value || out_if.final_item !== want.fin ||
              out_if.count_mismatch !== want.mism) begin
            fails++;
            if (fails <= 10)
              $display("mismatch exp %0d %h %h %b %b got %0d %h %h %b %b",
                       want.index, want.when, want.value, want.fin, want.mism,
                       out_if.sample_index, out_if.sample_time, out_if.sample_value,
                       out_if.final_item, out_if.count_mismatch);
          end
        end
      end
      if (!hold_done && got_count >= 40) begin
        hold_done = 1;
        hold = 300;   // queue fills, bytes channel must stall
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 0;
      end else if (cyc[9:8] == 2'd0) begin
        out_if.ready <= 1;
      end else begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_byte(logic [7:0] d, logic l);
    byte_queue.push_back('{data: d, last: l});
    typed_queue.push_back(1'b0);
  endtask

  task automatic apb_write(logic [rusd_pkg::APB_ADDR_W-1:0] a, logic [31:0] d);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= a; pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    step_bits = d;
  endtask

  task automatic wait_idle();
    while (byte_queue.size() > 0 || in_if.valid || pending_samples.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 32'h3F80_0000;
      1: return 32'h7F7F_FFFF;
      2: return 32'h0000_0001;
      3: return 32'h7F80_0000;
      4: return 32'hFFC0_0001;
      5: return {1'($urandom_range(0, 1)), 31'd0};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_item();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return {16'($urandom), 1'b0, 5'h1F, 10'($urandom)};
      4: return {16'($urandom), 1'b1, 5'h00, 10'($urandom)};
      5: return 32'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // one random upload; most are well formed, some broken or off-count
  task automatic queue_upload();
    int n, sz, cut, total, k;
    logic [7:0] hdr[7];
    logic [31:0] sc, v;
    logic [15:0] cnt;
    logic [3:0] nib;
    logic [7:0] bytes_all[$];
    case ($urandom_range(0, 3))
      0: nib = 4'd4;
      1: nib = 4'd5;
      2: nib = 4'd1;
      default: nib = 4'($urandom);
    endcase
    n = $urandom_range(0, 8);
    cnt = ($urandom_range(0, 3) != 0) ? 16'(n) : 16'($urandom);
    sc = pick_scale();
    hdr = '{{nib, 4'($urandom)}, cnt[7:0], cnt[15:8], sc[7:0], sc[15:8], sc[23:16],
            sc[31:24]};
    foreach (hdr[i]) bytes_all.push_back(hdr[i]);
    sz = (nib == 4'd1) ? 2 : 4;
    for (int i = 0; i < n; i++) begin
      v = pick_item();
      for (int j = 0; j < sz; j++) bytes_all.push_back(v[j*8 +: 8]);
    end
    total = bytes_all.size();
    // broken upload: last falls at a random byte, in the header or among the items
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, total) : total;
    for (k = 0; k < cut; k++) queue_byte(bytes_all[k], k == cut - 1);
  endtask

  dir_row_t dir_rows[$];

  task automatic add_row(logic [7:0] d, logic l);
    dir_rows.push_back('{data: d, last: l, typed: 1'b0, want: '{default: '0}});
  endtask

  task automatic add_row_typed(logic [7:0] d, logic l, sample_t w);
    dir_rows.push_back('{data: d, last: l, typed: 1'b1, want: w});
  endtask

  initial begin : stimulus
    logic [31:0] steps[6];
    int sent;
    psel = 0; penable = 0; pwrite = 0; paddr = rusd_pkg::REG_STEP_ADDR; pwdata = 0;
    @(negedge rst);
    @(posedge clk);

    // int32 upload, one item 2 at scale 1.0: value 2.0, time 0, count matches
    add_row(8'h40, 0); add_row(8'h01, 0); add_row(8'h00, 0);
    add_row(8'h00, 0); add_row(8'h00, 0); add_row(8'h80, 0); add_row(8'h3F, 0);
    add_row(8'h02, 0); add_row(8'h00, 0); add_row(8'h00, 0);
    add_row_typed(8'h00, 1, '{index: 16'd0, when: 32'd0, value: 32'h4000_0000,
                              fin: 1'b1, mism: 1'b0});
    // half upload at max scale: infinity, a subnormal, NaN on the last byte
    add_row(8'h1F, 0); add_row(8'h03, 0); add_row(8'h00, 0);
    add_row(8'hFF, 0); add_row(8'hFF, 0); add_row(8'h7F, 0); add_row(8'h7F, 0);
    add_row(8'h00, 0); add_row(8'h7C, 0);
    add_row(8'h01, 0); add_row(8'h00, 0);
    add_row(8'hFF, 0);
    add_row_typed(8'hFF, 1, '{index: 16'd2,
                              when: fmul32(32'h4000_0000, rusd_pkg::STEP_RESET),
                              value: rusd_pkg::QNAN_BITS, fin: 1'b1, mism: 1'b0});
    // last byte inside the header: dropped, no sample
    add_row(8'h50, 0);
    add_row(8'hFF, 1);
    foreach (dir_rows[i]) begin
      byte_queue.push_back('{data: dir_rows[i].data, last: dir_rows[i].last});
      typed_queue.push_back(dir_rows[i].typed);
      if (dir_rows[i].typed) typed_want.push_back(dir_rows[i].want);
    end
    wait_idle();

    // step settings: zero, extremes, NaN, random, and back to reset
    steps = '{32'h0000_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'hFFFF_FFFF,
              $urandom, rusd_pkg::STEP_RESET};
    foreach (steps[p]) begin
      apb_write(rusd_pkg::REG_STEP_ADDR, steps[p]);
      sent = 0;
      while (sent < 85) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_byte(8'($urandom), 1'($urandom_range(0, 1)));   // noise
          sent++;
        end else begin
          sent -= byte_queue.size();
          queue_upload();
          sent += byte_queue.size();
        end
        while (byte_queue.size() > 16) @(posedge clk);
      end
      // close any open upload before the register moves
      queue_byte(8'h00, 1);
      wait_idle();
    end

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/rusd_pkg.sv
src/rusd_ifs.sv
src/rusd_front.sv
src/rusd_queue.sv
src/rusd_back.sv
src/recorder_upload_sample_decoder_core.sv
src/rusd_checker.sv
tb/tb.sv
